// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the split butterfly top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every rising clock edge outside reset.
`define RFSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define RFSB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ===== design/rfsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsb_pkg
// Codes, control types and fixed widths of the real FFT split butterfly.
// ----------------------------------------------------------------------------
package rfsb_pkg;

  localparam int OUT_BITS       = 26;
  localparam int OUT_TDATA_BITS = ((4 * OUT_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS   = 3;
  localparam int PIPE_STAGES    = 5;

  typedef enum logic {
    CMD_FORWARD  = 1'b0,
    CMD_BACKWARD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    POS_ENDPOINT = 2'd0,
    POS_MIDDLE   = 2'd1,
    POS_CENTRE   = 2'd2
  } pos_e;

  typedef struct packed {
    logic fwd;
    logic mid;
  } ctl_t;

endpackage

// ===== design/rfsb_prep.sv =====
// ----------------------------------------------------------------------------
// rfsb_prep
// Command decode, butterfly pre-adders and the endpoint and centre results.
// ----------------------------------------------------------------------------
module rfsb_prep #(
  parameter int SAMPLE_BITS = 24
) (
  input  rfsb_pkg::cmd_e           command_i,
  input  logic [1:0]               position_i,
  input  logic signed [SAMPLE_BITS-1:0] low_re_i,
  input  logic signed [SAMPLE_BITS-1:0] low_im_i,
  input  logic signed [SAMPLE_BITS-1:0] high_re_i,
  input  logic signed [SAMPLE_BITS-1:0] high_im_i,
  output rfsb_pkg::ctl_t           ctl_o,
  output logic signed [SAMPLE_BITS:0]   re_o,
  output logic signed [SAMPLE_BITS:0]   ie_o,
  output logic signed [SAMPLE_BITS:0]   x_o,
  output logic signed [SAMPLE_BITS:0]   y_o,
  output logic signed [SAMPLE_BITS+1:0] lr_o,
  output logic signed [SAMPLE_BITS+1:0] li_o,
  output logic signed [SAMPLE_BITS+1:0] hr_o,
  output logic signed [SAMPLE_BITS+1:0] hi_o
);
  import rfsb_pkg::*;

  localparam int SW = SAMPLE_BITS + 2;
  localparam int PW = SAMPLE_BITS + 1;

  logic signed [SW-1:0] a;
  logic signed [SW-1:0] b;
  logic signed [SW-1:0] c;
  logic signed [SW-1:0] d;
  pos_e                 pos;
  logic                 fwd;

  assign a   = SW'(low_re_i);
  assign b   = SW'(low_im_i);
  assign c   = SW'(high_re_i);
  assign d   = SW'(high_im_i);
  assign pos = pos_e'(position_i);
  assign fwd = (command_i == CMD_FORWARD);

  assign ctl_o.fwd = fwd;
  assign ctl_o.mid = (pos == POS_MIDDLE);

  // The multiplier operands are the difference pair of the forward split and
  // the rotated pair of the backward merge.
  assign re_o = PW'(a + c);
  assign ie_o = PW'(b - d);
  assign x_o  = fwd ? PW'(c - a) : PW'(b + d);
  assign y_o  = fwd ? PW'(b + d) : PW'(a - c);

  always_comb begin
    lr_o = a;
    li_o = b;
    hr_o = c;
    hi_o = d;
    if (fwd) begin
      unique case (pos)
        POS_ENDPOINT: begin
          lr_o = a + b;
          li_o = '0;
          hr_o = a - b;
          hi_o = '0;
        end
        POS_CENTRE: begin
          li_o = -b;
        end
        default: begin
        end
      endcase
    end else begin
      unique case (pos)
        POS_ENDPOINT: begin
          lr_o = a + c;
          li_o = a - c;
        end
        POS_CENTRE: begin
          lr_o = a <<< 1;
          li_o = -(b <<< 1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/rfsb_cmul.sv =====
// ----------------------------------------------------------------------------
// rfsb_cmul
// The four partial products of the complex twiddle multiply.
// ----------------------------------------------------------------------------
module rfsb_cmul #(
  parameter int SAMPLE_BITS       = 24,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic signed [SAMPLE_BITS:0]                     x_i,
  input  logic signed [SAMPLE_BITS:0]                     y_i,
  input  logic signed [TWIDDLE_FRAC_BITS+1:0]             wr_i,
  input  logic signed [TWIDDLE_FRAC_BITS+1:0]             wi_i,
  output logic signed [SAMPLE_BITS+TWIDDLE_FRAC_BITS+2:0] xr_o,
  output logic signed [SAMPLE_BITS+TWIDDLE_FRAC_BITS+2:0] yi_o,
  output logic signed [SAMPLE_BITS+TWIDDLE_FRAC_BITS+2:0] yr_o,
  output logic signed [SAMPLE_BITS+TWIDDLE_FRAC_BITS+2:0] xi_o
);

  localparam int PRW = SAMPLE_BITS + TWIDDLE_FRAC_BITS + 3;

  assign xr_o = PRW'(x_i) * PRW'(wr_i);
  assign yi_o = PRW'(y_i) * PRW'(wi_i);
  assign yr_o = PRW'(y_i) * PRW'(wr_i);
  assign xi_o = PRW'(x_i) * PRW'(wi_i);

endmodule

// ===== design/rfsb_rndsat.sv =====
// ----------------------------------------------------------------------------
// rfsb_rndsat
// Round to nearest with ties upward after the fraction shift, then saturate
// to the output width.
// ----------------------------------------------------------------------------
module rfsb_rndsat #(
  parameter int IN_BITS   = 45,
  parameter int FRAC_BITS = 16
) (
  input  logic signed [IN_BITS-1:0]            v_i,
  input  logic                                 half_i,
  output logic signed [rfsb_pkg::OUT_BITS-1:0] q_o
);
  import rfsb_pkg::*;

  localparam int TW = IN_BITS + 1;
  localparam int EW = (TW > OUT_BITS) ? TW : OUT_BITS + 1;
  localparam logic signed [TW-1:0] RndHalf = TW'(1) <<< FRAC_BITS;
  localparam logic signed [TW-1:0] RndFull = TW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] MaxV =
    {{(EW - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
  localparam logic signed [EW-1:0] MinV = ~MaxV;

  logic signed [TW-1:0] t;
  logic signed [TW-1:0] r;
  logic signed [EW-1:0] e;

  // The halving of the forward split is one more bit of shift.
  assign t = TW'(v_i) + (half_i ? RndHalf : RndFull);
  assign r = half_i ? (t >>> (FRAC_BITS + 1)) : (t >>> FRAC_BITS);
  assign e = EW'(r);

  always_comb begin
    if (e > MaxV) begin
      q_o = OUT_BITS'(MaxV);
    end else if (e < MinV) begin
      q_o = OUT_BITS'(MinV);
    end else begin
      q_o = OUT_BITS'(e);
    end
  end

endmodule

// ===== design/real_fft_split_butterfly.sv =====
// ----------------------------------------------------------------------------
// real_fft_split_butterfly
// An input transfer passes through all five registered stages to the result on the master side.
// Throughput is one bin pair per cycle while the master side accepts results; each
// of the five stages has its own valid bit and is refilled whenever it empties, and
// the twiddle multiply uses one set of four multipliers in its own stage.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module real_fft_split_butterfly #(
  parameter int SAMPLE_BITS       = 24,
  parameter int TWIDDLE_FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // low_re, low_im, high_re, high_im, tw_re, tw_im, zero padding
  input  logic [((4*SAMPLE_BITS+2*(TWIDDLE_FRAC_BITS+2)+7)/8)*8-1:0] s_axis_tdata,
  // command, position
  input  logic [rfsb_pkg::IN_USER_BITS-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_low_re, new_low_im, new_high_re, new_high_im
  output logic [rfsb_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import rfsb_pkg::*;

  localparam int SW  = SAMPLE_BITS + 2;
  localparam int PW  = SAMPLE_BITS + 1;
  localparam int TWW = TWIDDLE_FRAC_BITS + 2;
  localparam int PRW = SAMPLE_BITS + TWIDDLE_FRAC_BITS + 3;
  localparam int MW  = SAMPLE_BITS + TWIDDLE_FRAC_BITS + 4;
  localparam int VW  = SAMPLE_BITS + TWIDDLE_FRAC_BITS + 5;

  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES:0]   rdy;
  logic [PIPE_STAGES-1:0] up_v;
  logic [PIPE_STAGES-1:0] en;

  logic signed [SAMPLE_BITS-1:0] low_re;
  logic signed [SAMPLE_BITS-1:0] low_im;
  logic signed [SAMPLE_BITS-1:0] high_re;
  logic signed [SAMPLE_BITS-1:0] high_im;

  ctl_t                 ctl1_d;
  logic signed [PW-1:0] re1_d, ie1_d, x1_d, y1_d;
  logic signed [SW-1:0] sm1_d [4];

  ctl_t                  ctl1_q, ctl2_q, ctl3_q;
  logic signed [PW-1:0]  re1_q, ie1_q, x1_q, y1_q;
  logic signed [TWW-1:0] wr1_q, wi1_q;
  logic signed [SW-1:0]  sm1_q [4];
  logic signed [SW-1:0]  sm2_q [4];
  logic signed [SW-1:0]  sm3_q [4];

  logic signed [PRW-1:0] p2_d [4];
  logic signed [PRW-1:0] p2_q [4];
  logic signed [PW-1:0]  re2_q, ie2_q, re3_q, ie3_q;

  logic signed [MW-1:0] m1_d, m2_d, m1_q, m2_q;

  logic signed [VW-1:0] re_s, ie_s, m1e, m2e;
  logic signed [VW-1:0] v4_d [4];
  logic signed [VW-1:0] v4_q [4];
  logic                 half4_q;

  logic signed [OUT_BITS-1:0] out_d [4];
  logic signed [OUT_BITS-1:0] out_q [4];

  // Per-stage handshake: a stage takes new data when it is empty or moves on.
  assign up_v = {v_q[PIPE_STAGES-2:0], s_axis_tvalid};

  always_comb begin
    rdy[PIPE_STAGES] = m_axis_tready;
    for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign en            = rdy[PIPE_STAGES-1:0] & up_v;
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[PIPE_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        if (rdy[i]) begin
          v_q[i] <= up_v[i];
        end
      end
    end
  end

  assign low_re  = s_axis_tdata[0 +: SAMPLE_BITS];
  assign low_im  = s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS];
  assign high_re = s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
  assign high_im = s_axis_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];

  rfsb_prep #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_prep (
    .command_i (cmd_e'(s_axis_tuser[0])),
    .position_i(s_axis_tuser[2:1]),
    .low_re_i  (low_re),
    .low_im_i  (low_im),
    .high_re_i (high_re),
    .high_im_i (high_im),
    .ctl_o     (ctl1_d),
    .re_o      (re1_d),
    .ie_o      (ie1_d),
    .x_o       (x1_d),
    .y_o       (y1_d),
    .lr_o      (sm1_d[0]),
    .li_o      (sm1_d[1]),
    .hr_o      (sm1_d[2]),
    .hi_o      (sm1_d[3])
  );

  rfsb_cmul #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
  ) u_cmul (
    .x_i (x1_q),
    .y_i (y1_q),
    .wr_i(wr1_q),
    .wi_i(wi1_q),
    .xr_o(p2_d[0]),
    .yi_o(p2_d[1]),
    .yr_o(p2_d[2]),
    .xi_o(p2_d[3])
  );

  // Forward split: tr = x*wr - y*wi, ti = y*wr + x*wi.
  // Backward merge: rd = x*wr + y*wi, id = y*wr - x*wi.
  assign m1_d = ctl2_q.fwd ? (MW'(p2_q[0]) - MW'(p2_q[1])) : (MW'(p2_q[0]) + MW'(p2_q[1]));
  assign m2_d = ctl2_q.fwd ? (MW'(p2_q[2]) + MW'(p2_q[3])) : (MW'(p2_q[2]) - MW'(p2_q[3]));

  assign re_s = VW'(re3_q) <<< TWIDDLE_FRAC_BITS;
  assign ie_s = VW'(ie3_q) <<< TWIDDLE_FRAC_BITS;
  assign m1e  = VW'(m1_q);
  assign m2e  = VW'(m2_q);

  // Endpoint and centre results are scaled up so that the same rounding
  // shift hands them back unchanged.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      v4_d[k] = VW'(sm3_q[k]) <<< TWIDDLE_FRAC_BITS;
    end
    if (ctl3_q.mid) begin
      if (ctl3_q.fwd) begin
        v4_d[0] = re_s + m2e;
        v4_d[1] = ie_s + m1e;
        v4_d[2] = re_s - m2e;
        v4_d[3] = m1e - ie_s;
      end else begin
        v4_d[0] = re_s - m1e;
        v4_d[1] = ie_s + m2e;
        v4_d[2] = re_s + m1e;
        v4_d[3] = m2e - ie_s;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_rnd
    rfsb_rndsat #(
      .IN_BITS  (VW),
      .FRAC_BITS(TWIDDLE_FRAC_BITS)
    ) u_rndsat (
      .v_i   (v4_q[g]),
      .half_i(half4_q),
      .q_o   (out_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl1_q <= ctl1_d;
      re1_q  <= re1_d;
      ie1_q  <= ie1_d;
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      wr1_q  <= s_axis_tdata[4*SAMPLE_BITS +: TWW];
      wi1_q  <= s_axis_tdata[4*SAMPLE_BITS+TWW +: TWW];
      sm1_q  <= sm1_d;
    end
    if (en[1]) begin
      ctl2_q <= ctl1_q;
      re2_q  <= re1_q;
      ie2_q  <= ie1_q;
      p2_q   <= p2_d;
      sm2_q  <= sm1_q;
    end
    if (en[2]) begin
      ctl3_q <= ctl2_q;
      re3_q  <= re2_q;
      ie3_q  <= ie2_q;
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      sm3_q  <= sm2_q;
    end
    if (en[3]) begin
      half4_q <= ctl3_q.mid && ctl3_q.fwd;
      v4_q    <= v4_d;
    end
    if (en[4]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = {out_q[3], out_q[2], out_q[1], out_q[0]};

  `RFSB_ASSERT_RST(a_reset_empty, !rst_ni |=> v_q == '0, "pipeline not empty in reset")
  `RFSB_ASSERT(a_in_lands, s_axis_tvalid && s_axis_tready |=> v_q[0], "transfer was lost")
  `RFSB_ASSERT(a_full_stalls, v_q[0] && !rdy[1] |-> !s_axis_tready, "input taken while full")
  `RFSB_ASSERT(a_stage4_holds, v_q[3] && !rdy[4] |=> v_q[3] && $stable(half4_q), "stall lost")
  `RFSB_ASSERT(a_out_source, $rose(m_axis_tvalid) |-> $past(v_q[3]), "result from nowhere")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the real FFT split butterfly. A queue of bin pairs
// (a directed set of extremes and every command and position, then random
// pairs) feeds the slave side in bursts. Each accepted transfer is predicted
// in the bench, and results on the master side are compared field by field in
// order while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import rfsb_pkg::*;

  localparam int SB            = 24;
  localparam int TFB           = 16;
  localparam int IN_TDATA_BITS = ((4 * SB + 2 * (TFB + 2) + 7) / 8) * 8;
  localparam int RANDOM_PAIRS  = 1630;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 4 * PIPE_STAGES + 20;

  localparam logic signed [SB-1:0]  S_MAX  = SB'(8388607);
  localparam logic signed [SB-1:0]  S_MIN  = SB'(-8388608);
  localparam logic signed [TFB+1:0] TW_POS = (TFB + 2)'(65536);
  localparam logic signed [TFB+1:0] TW_NEG = (TFB + 2)'(-65536);
  localparam longint TW_UNIT = 64'sd1 <<< TFB;
  localparam longint OUT_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (OUT_BITS - 1));

  typedef struct {
    cmd_e                    cmd;
    logic [1:0]              pos;
    logic signed [SB-1:0]    lr;
    logic signed [SB-1:0]    li;
    logic signed [SB-1:0]    hr;
    logic signed [SB-1:0]    hi;
    logic signed [TFB+1:0]   wr;
    logic signed [TFB+1:0]   wi;
    bit                      drain_first;
  } bin_pair_t;

  typedef logic [3:0][OUT_BITS-1:0] bins_out_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic [IN_USER_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  bin_pair_t pending[$];
  bins_out_t bins_due[$];
  int errors = 0;

  real_fft_split_butterfly #(
    .SAMPLE_BITS      (SB),
    .TWIDDLE_FRAC_BITS(TFB)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic logic [OUT_BITS-1:0] clip_out(longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[OUT_BITS-1:0];
  endfunction

  // Divides by 2^s and rounds to nearest, ties toward plus infinity.
  function automatic longint round_div(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic bins_out_t split_merge(bin_pair_t p);
    longint a = p.lr;
    longint b = p.li;
    longint c = p.hr;
    longint d = p.hi;
    longint wr = p.wr;
    longint wi = p.wi;
    longint nlr = a;
    longint nli = b;
    longint nhr = c;
    longint nhi = d;
    longint re, ie, rd, id, tr, ti;
    bins_out_t r;
    if (p.cmd == CMD_FORWARD) begin
      if (p.pos == POS_ENDPOINT) begin
        nlr = a + b;
        nhr = a - b;
        nli = 0;
        nhi = 0;
      end else if (p.pos == POS_MIDDLE) begin
        re = a + c;
        ie = b - d;
        rd = c - a;
        id = b + d;
        tr = rd * wr - id * wi;
        ti = id * wr + rd * wi;
        nlr = round_div(re * TW_UNIT + ti, TFB + 1);
        nli = round_div(ie * TW_UNIT + tr, TFB + 1);
        nhr = round_div(re * TW_UNIT - ti, TFB + 1);
        nhi = round_div(tr - ie * TW_UNIT, TFB + 1);
      end else if (p.pos == POS_CENTRE) begin
        nli = -b;
      end
    end else begin
      if (p.pos == POS_ENDPOINT) begin
        nlr = a + c;
        nli = a - c;
      end else if (p.pos == POS_MIDDLE) begin
        re = a + c;
        ti = a - c;
        ie = b - d;
        tr = b + d;
        rd = tr * wr + ti * wi;
        id = ti * wr - tr * wi;
        nlr = round_div(re * TW_UNIT - rd, TFB);
        nli = round_div(ie * TW_UNIT + id, TFB);
        nhr = round_div(re * TW_UNIT + rd, TFB);
        nhi = round_div(id - ie * TW_UNIT, TFB);
      end else if (p.pos == POS_CENTRE) begin
        nlr = 2 * a;
        nli = -2 * b;
      end
    end
    r[0] = clip_out(nlr);
    r[1] = clip_out(nli);
    r[2] = clip_out(nhr);
    r[3] = clip_out(nhi);
    return r;
  endfunction

  function automatic bin_pair_t make_pair(cmd_e cmd, logic [1:0] pos,
                                          logic signed [SB-1:0] lr,
                                          logic signed [SB-1:0] li,
                                          logic signed [SB-1:0] hr,
                                          logic signed [SB-1:0] hi,
                                          logic signed [TFB+1:0] wr,
                                          logic signed [TFB+1:0] wi);
    bin_pair_t p;
    p.cmd = cmd;
    p.pos = pos;
    p.lr = lr;
    p.li = li;
    p.hr = hr;
    p.hi = hi;
    p.wr = wr;
    p.wi = wi;
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample(int style);
    int pick;
    pick = $urandom_range(0, 2);
    if (style < 6) return SB'($urandom);
    if (style < 8) return (pick == 0) ? S_MAX : (pick == 1) ? S_MIN : '0;
    return SB'($urandom_range(0, 32) - 16);
  endfunction

  function automatic logic signed [TFB+1:0] rand_twiddle();
    int style;
    int pick;
    style = $urandom_range(0, 9);
    pick = $urandom_range(0, 2);
    if (style < 7) return (TFB + 2)'($urandom_range(0, 131072) - 65536);
    if (style == 7) return (pick == 0) ? TW_POS : (pick == 1) ? TW_NEG : '0;
    return (TFB + 2)'($urandom_range(0, 8) - 4);
  endfunction

  function automatic bin_pair_t rand_pair();
    bin_pair_t p;
    int style;
    int pick;
    style = $urandom_range(0, 9);
    pick = $urandom_range(0, 99);
    p.cmd = cmd_e'($urandom_range(0, 1));
    if (pick < 8) p.pos = POS_ENDPOINT;
    else if (pick < 16) p.pos = POS_CENTRE;
    else if (pick < 20) p.pos = 2'd3;
    else p.pos = POS_MIDDLE;
    p.lr = rand_sample(style);
    p.li = rand_sample(style);
    p.hr = rand_sample(style);
    p.hi = rand_sample(style);
    p.wr = rand_twiddle();
    p.wi = rand_twiddle();
    p.drain_first = 1'b0;
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    bin_pair_t p;
    for (int cmd = 0; cmd < 2; cmd++) begin
      for (int pos = 0; pos < 4; pos++) begin
        pending.push_back(make_pair(cmd_e'(cmd), pos[1:0], S_MAX, S_MIN, S_MAX, S_MIN,
                                    TW_POS, TW_NEG));
        pending.push_back(make_pair(cmd_e'(cmd), pos[1:0], S_MIN, S_MIN, S_MIN, S_MIN,
                                    TW_NEG, TW_POS));
      end
      pending.push_back(make_pair(cmd_e'(cmd), POS_MIDDLE, '0, '0, '0, '0, '0, '0));
      pending.push_back(make_pair(cmd_e'(cmd), POS_MIDDLE, S_MAX, S_MAX, S_MAX, S_MAX,
                                  TW_POS, '0));
      pending.push_back(make_pair(cmd_e'(cmd), POS_MIDDLE, SB'(1), '0, '0, SB'(-1),
                                  (TFB + 2)'(1), (TFB + 2)'(-1)));
    end
    pending.push_back(make_pair(CMD_FORWARD, POS_ENDPOINT, S_MAX, S_MAX, '0, '0, '0, '0));
    pending.push_back(make_pair(CMD_BACKWARD, POS_CENTRE, S_MIN, S_MAX, '0, '0, '0, '0));
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p = rand_pair();
      p.drain_first = (i == 400) || (i == 1200);
      pending.push_back(p);
    end

    do @(posedge clk_i);
    while (!rst_ni || pending.size() != 0 || s_axis_tvalid || bins_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bins_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, bins_due.size());
    end
    if (errors == 0 && bins_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  bin_pair_t drv_pair;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() != 0 &&
                   !(pending[0].drain_first && (s_axis_tvalid || bins_due.size() != 0))) begin
        drv_pair = pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, drv_pair.wi, drv_pair.wr, drv_pair.hi, drv_pair.hr,
                         drv_pair.li, drv_pair.lr};
        s_axis_tuser <= {drv_pair.pos, drv_pair.cmd};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  int ready_mode = 0;
  int ready_left = 0;
  int ready_phase = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        ready_left <= $urandom_range(16, 200);
      end else begin
        ready_left <= ready_left - 1;
      end
      ready_phase <= ready_phase + 1;
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (ready_phase % 7) > 2;
      endcase
    end
  end

  bin_pair_t seen_pair;
  bins_out_t want_bins;
  bins_out_t got_bins;
  string bin_names[4] = '{"new_low_re", "new_low_im", "new_high_re", "new_high_im"};

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_pair.cmd = cmd_e'(s_axis_tuser[0]);
        seen_pair.pos = s_axis_tuser[2:1];
        seen_pair.lr = s_axis_tdata[0*SB +: SB];
        seen_pair.li = s_axis_tdata[1*SB +: SB];
        seen_pair.hr = s_axis_tdata[2*SB +: SB];
        seen_pair.hi = s_axis_tdata[3*SB +: SB];
        seen_pair.wr = s_axis_tdata[4*SB +: TFB + 2];
        seen_pair.wi = s_axis_tdata[4*SB + TFB + 2 +: TFB + 2];
        seen_pair.drain_first = 1'b0;
        bins_due.push_back(split_merge(seen_pair));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_bins = m_axis_tdata[4*OUT_BITS-1:0];
        if (bins_due.size() == 0) begin
          errors++;
          if (errors < 50) begin
            $display("%0t: result transfer with nothing pending, actual %h", $time, got_bins);
          end
        end else begin
          want_bins = bins_due.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got_bins[i] !== want_bins[i]) begin
              errors++;
              if (errors < 50) begin
                $display("%0t: %s expected %0d actual %0d", $time, bin_names[i],
                         $signed(want_bins[i]), $signed(got_bins[i]));
              end
            end
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ===== real_fft_split_butterfly.f =====
+incdir+design
design/rfsb_pkg.sv
design/rfsb_prep.sv
design/rfsb_cmul.sv
design/rfsb_rndsat.sv
design/real_fft_split_butterfly.sv
verif/tb_top.sv
